[src/clng_pkg.sv]
// Shared types and constants for the cell list neighbour generator.
// No dependencies.
package clng_pkg;

    localparam int CFG_W          = 7;   // cell count register width
    localparam int MASK_W         = 3;   // periodic mask width
    localparam int INDEX_W        = 18;  // cell index port width
    localparam int LIST_DEPTH     = 27;
    localparam int COUNT_W        = 5;
    localparam int AXIS_CNT       = 3;
    localparam int AXIS_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_CELLS_DEF  = 64;
    localparam int AXES_DEF       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_X   = 2'd0,
        REG_CELLS_Y   = 2'd1,
        REG_CELLS_Z   = 2'd2,
        REG_PERIODIC  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic plus;   // 1: +1 step, 0: -1 step
        logic wrap;   // axis is periodic
    } t_step_ctl;

endpackage

[src/cell_list_neighbour_generator.sv]
// Cell list neighbour generator, top level: config registers, sequencer, list store.
// Depends on clng_pkg and clng_step.
//
// A start transfer takes one linear cell index and the block stays busy until all of its
// results are out. Setup does the two grid-size multiplies and then the range check; then a
// shared compare-subtract unit splits the index into coordinates at one quotient bit per
// cycle, AW bits each for z and y, with AW the bit count of min(MAX_CELLS_PER_AXIS, 127).
// Expansion visits each list entry of the previous axes twice (-1 step, +1 step), and
// non-periodic edges drop steps; a flush state then gives the final result. An index
// outside the grid gives its single error result from the range check. Results come one
// per o_valid cycle and cannot be held off.
module cell_list_neighbour_generator
    import clng_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
    parameter int AXES               = AXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [INDEX_W-1:0]   i_cell_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [INDEX_W-1:0]   o_neighbour_index,
    output logic                 o_last,
    output logic                 o_index_error
);

    localparam int REG_MAX = (1 << CFG_W) - 1;
    localparam int CLAMP   = (MAX_CELLS_PER_AXIS < REG_MAX) ? MAX_CELLS_PER_AXIS : REG_MAX;
    localparam int AW      = $clog2(CLAMP + 1);
    localparam int IW      = 3 * AW;
    localparam int CMP_W   = (INDEX_W > IW) ? INDEX_W : IW;
    localparam int CNT_W   = $clog2(AW);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_CHECK, S_DIVZ, S_DIVY, S_EXPM, S_EXPP, S_FLUSH
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cells_x, r_cells_y, r_cells_z;
    logic [MASK_W-1:0]    r_periodic_mask;

    logic [INDEX_W-1:0]   r_cell;
    logic [AW-1:0]        r_nx, r_ny, r_nz;
    logic [MASK_W-1:0]    r_wrap;
    logic [2*AW-1:0]      r_s1;
    logic [IW-1:0]        r_tot;
    logic [IW-1:0]        r_rem, r_dvs;
    logic [AW-1:0]        r_q, r_z;
    logic [CNT_W-1:0]     r_cnt;
    logic [IW-1:0]        r_pend;
    logic [COUNT_W-1:0]   r_count, r_base, r_k;
    logic [AXIS_W-1:0]    r_axis;

    logic                 r_valid, r_last, r_err;
    logic [INDEX_W-1:0]   r_out_idx;

    logic [IW-1:0]        r_list_idx [LIST_DEPTH];
    logic [AW-1:0]        r_list_crd [LIST_DEPTH][AXIS_CNT];

    logic [CMP_W-1:0]     w_cell_ext;
    logic                 w_ge;
    logic [IW-1:0]        w_rem_nx;
    logic [AW-1:0]        w_q_nx;
    logic [IW-1:0]        w_f, w_spanm;
    logic [AW-1:0]        w_n;
    t_step_ctl            w_ctl;
    logic                 w_ok;
    logic [IW-1:0]        w_new_idx;
    logic [AW-1:0]        w_new_coord;
    logic [AW-1:0]        w_new_crd [AXIS_CNT];
    logic                 w_div_end;

    function automatic logic [AW-1:0] f_clamp(input logic [CFG_W-1:0] v);
        if (32'(v) > CLAMP) begin
            return AW'(CLAMP);
        end
        return AW'(v);
    endfunction

    assign busy = (r_state != S_IDLE);

    assign o_valid           = r_valid;
    assign o_neighbour_index = r_out_idx;
    assign o_last            = r_last;
    assign o_index_error     = r_err;

    assign w_cell_ext = CMP_W'(r_cell);

    // shared restoring division step
    assign w_ge      = (r_rem >= r_dvs);
    assign w_rem_nx  = w_ge ? (r_rem - r_dvs) : r_rem;
    assign w_q_nx    = AW'({r_q, w_ge});
    assign w_div_end = (r_cnt == '0);

    always_comb begin
        unique case (r_axis)
            2'd0: begin
                w_f     = IW'(1);
                w_spanm = IW'(r_nx) - IW'(1);
                w_n     = r_nx;
            end
            2'd1: begin
                w_f     = IW'(r_nx);
                w_spanm = IW'(r_s1) - IW'(r_nx);
                w_n     = r_ny;
            end
            default: begin
                w_f     = IW'(r_s1);
                w_spanm = r_tot - IW'(r_s1);
                w_n     = r_nz;
            end
        endcase
        w_ctl.plus = (r_state == S_EXPP);
        w_ctl.wrap = r_wrap[r_axis];
    end

    clng_step #(
        .AW (AW),
        .IW (IW)
    ) u_step (
        .i_idx   (r_list_idx[r_k]),
        .i_coord (r_list_crd[r_k][r_axis]),
        .i_n     (w_n),
        .i_f     (w_f),
        .i_spanm (w_spanm),
        .i_ctl   (w_ctl),
        .o_ok    (w_ok),
        .o_idx   (w_new_idx),
        .o_coord (w_new_coord)
    );

    always_comb begin
        w_new_crd = r_list_crd[r_k];
        w_new_crd[r_axis] = w_new_coord;
    end

    // neighbour list store
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIVY && w_div_end) begin
            r_list_idx[0]    <= w_cell_ext[IW-1:0];
            r_list_crd[0][0] <= w_rem_nx[AW-1:0];
            r_list_crd[0][1] <= w_q_nx;
            r_list_crd[0][2] <= r_z;
        end else if ((r_state == S_EXPM || r_state == S_EXPP) && w_ok) begin
            r_list_idx[r_count] <= w_new_idx;
            r_list_crd[r_count] <= w_new_crd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cells_x       <= CFG_W'(1);
            r_cells_y       <= CFG_W'(1);
            r_cells_z       <= CFG_W'(1);
            r_periodic_mask <= '0;
            r_valid         <= 1'b0;
            r_last          <= 1'b0;
            r_err           <= 1'b0;
            r_count         <= '0;
            r_base          <= '0;
            r_k             <= '0;
            r_axis          <= '0;
            r_cnt           <= '0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_err   <= 1'b0;

            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_CELLS_X:  r_cells_x       <= i_cfg_data;
                    REG_CELLS_Y:  r_cells_y       <= i_cfg_data;
                    REG_CELLS_Z:  r_cells_z       <= i_cfg_data;
                    REG_PERIODIC: r_periodic_mask <= i_cfg_data[MASK_W-1:0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cell  <= i_cell_index;
                        r_nx    <= f_clamp(r_cells_x);
                        r_ny    <= f_clamp(r_cells_y);
                        r_nz    <= f_clamp(r_cells_z);
                        r_wrap  <= r_periodic_mask;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_s1    <= (2*AW)'(r_nx) * (2*AW)'(r_ny);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_tot   <= IW'(r_s1) * IW'(r_nz);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_cell_ext >= CMP_W'(r_tot)) begin
                        r_valid   <= 1'b1;
                        r_last    <= 1'b1;
                        r_err     <= 1'b1;
                        r_out_idx <= '0;
                        r_count   <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_rem   <= w_cell_ext[IW-1:0];
                        r_dvs   <= IW'(r_s1) << (AW - 1);
                        r_q     <= '0;
                        r_cnt   <= CNT_W'(AW - 1);
                        r_state <= S_DIVZ;
                    end
                end
                S_DIVZ: begin
                    r_rem <= w_rem_nx;
                    r_dvs <= r_dvs >> 1;
                    r_q   <= w_q_nx;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (w_div_end) begin
                        r_z     <= w_q_nx;
                        r_q     <= '0;
                        r_dvs   <= IW'(r_nx) << (AW - 1);
                        r_cnt   <= CNT_W'(AW - 1);
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    r_rem <= w_rem_nx;
                    r_dvs <= r_dvs >> 1;
                    r_q   <= w_q_nx;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (w_div_end) begin
                        r_pend  <= w_cell_ext[IW-1:0];
                        r_count <= COUNT_W'(1);
                        r_base  <= COUNT_W'(1);
                        r_k     <= '0;
                        r_axis  <= '0;
                        r_state <= S_EXPM;
                    end
                end
                S_EXPM: begin
                    if (w_ok) begin
                        r_valid   <= 1'b1;
                        r_out_idx <= INDEX_W'(r_pend);
                        r_pend    <= w_new_idx;
                        r_count   <= r_count + COUNT_W'(1);
                    end
                    r_state <= S_EXPP;
                end
                S_EXPP: begin
                    if (w_ok) begin
                        r_valid   <= 1'b1;
                        r_out_idx <= INDEX_W'(r_pend);
                        r_pend    <= w_new_idx;
                        r_count   <= r_count + COUNT_W'(1);
                    end
                    if (r_k + COUNT_W'(1) == r_base) begin
                        r_k    <= '0;
                        r_base <= w_ok ? (r_count + COUNT_W'(1)) : r_count;
                        r_axis <= r_axis + AXIS_W'(1);
                        r_state <= (r_axis == AXIS_W'(AXES - 1)) ? S_FLUSH : S_EXPM;
                    end else begin
                        r_k     <= r_k + COUNT_W'(1);
                        r_state <= S_EXPM;
                    end
                end
                S_FLUSH: begin
                    r_valid   <= 1'b1;
                    r_last    <= 1'b1;
                    r_out_idx <= INDEX_W'(r_pend);
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/clng_step.sv]
// One neighbour step along one axis: edge test, wrap and index update.
// Depends on clng_pkg.
module clng_step
    import clng_pkg::*;
#(
    parameter int AW = 7,
    parameter int IW = 21
) (
    input  logic [IW-1:0] i_idx,
    input  logic [AW-1:0] i_coord,
    input  logic [AW-1:0] i_n,
    input  logic [IW-1:0] i_f,
    input  logic [IW-1:0] i_spanm,
    input  t_step_ctl     i_ctl,
    output logic          o_ok,
    output logic [IW-1:0] o_idx,
    output logic [AW-1:0] o_coord
);

    logic          w_edge;
    logic [AW:0]   w_up;
    logic [IW-1:0] w_op;
    logic          w_sub;

    assign w_up = {1'b0, i_coord} + (AW+1)'(1);

    always_comb begin
        if (i_ctl.plus) begin
            w_edge  = w_up >= {1'b0, i_n};
            w_sub   = w_edge;
            o_coord = w_edge ? '0 : w_up[AW-1:0];
        end else begin
            w_edge  = (i_coord == '0);
            w_sub   = !w_edge;
            o_coord = w_edge ? (i_n - AW'(1)) : (i_coord - AW'(1));
        end
        w_op  = w_edge ? i_spanm : i_f;
        o_idx = w_sub ? (i_idx - w_op) : (i_idx + w_op);
        o_ok  = !w_edge || i_ctl.wrap;
    end

endmodule
